>>> hw/rtl/vlc_pkg.sv
// ----------------------------------------------------------------------------
// vlc_pkg
// Shared types and constants of the vehicle lighting controller.
// ----------------------------------------------------------------------------
package vlc_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_VOLTAGE_INTERVAL    = 8'd0;
    localparam logic [7:0] CFG_INACTIVITY_LIMIT    = 8'd1;
    localparam logic [7:0] CFG_INACTIVITY_INTERVAL = 8'd2;
    localparam logic [7:0] CFG_BLINK_NAG           = 8'd3;
    localparam logic [7:0] CFG_LONG_PRESS          = 8'd4;
    localparam logic [7:0] CFG_ADC_CRITICAL        = 8'd5;
    localparam logic [7:0] CFG_ADC_EMPTY           = 8'd6;
    localparam logic [7:0] CFG_ADC_LOW             = 8'd7;

    // Delay before the first battery check
    localparam logic [31:0] INITIAL_CHECK_MS = 32'd1200;

    // Switch bit positions
    localparam int SW_LOW   = 0;
    localparam int SW_BRAKE = 1;
    localparam int SW_WORK  = 2;
    localparam int SW_HIGH  = 3;
    localparam int SW_HORN  = 4;
    localparam int SW_LEFT  = 5;
    localparam int SW_RIGHT = 6;
    localparam int SW_WARN  = 7;

    // Lamp bit positions
    localparam int LAMP_REAR_LEFT   = 0;
    localparam int LAMP_REAR_RIGHT  = 1;
    localparam int LAMP_FRONT_LEFT  = 2;
    localparam int LAMP_FRONT_RIGHT = 3;
    localparam int LAMP_WORK        = 4;
    localparam int LAMP_HIGH        = 5;
    localparam int LAMP_LOW         = 6;
    localparam int LAMP_HORN        = 7;

    typedef enum logic [1:0] {
        BEAM_OFF     = 2'd0,
        BEAM_HELD    = 2'd1,
        BEAM_LATCHED = 2'd2
    } t_beam_mode;

    typedef struct packed {
        logic [7:0]  switch_levels;
        logic [7:0]  switch_rises;
        logic [15:0] high_beam_press_ms;
        logic        blink_level;
        logic        blink_rise;
        logic [31:0] now_ms;
        logic [9:0]  battery_adc;
    } t_in_item;

    typedef struct packed {
        logic [7:0] lamp_outputs;
        logic       blink_restart;
        logic       beep_request;
        logic [3:0] beep_count;
        logic [9:0] beep_on_ms;
        logic [9:0] beep_off_ms;
    } t_out_item;

    typedef struct packed {
        logic [31:0] voltage_interval_ms;
        logic [31:0] inactivity_limit_ms;
        logic [31:0] inactivity_interval_ms;
        logic [15:0] blink_nag_ms;
        logic [15:0] long_press_ms;
        logic [9:0]  adc_critical;
        logic [9:0]  adc_empty;
        logic [9:0]  adc_low;
    } t_cfg;

    typedef struct packed {
        logic       request;
        logic [3:0] count;
        logic [9:0] on_ms;
        logic [9:0] off_ms;
    } t_beep;

    localparam t_beep BEEP_NONE     = '{1'b0, 4'd0,  10'd0,   10'd0};
    localparam t_beep BEEP_CRITICAL = '{1'b1, 4'd10, 10'd300, 10'd150};
    localparam t_beep BEEP_EMPTY    = '{1'b1, 4'd4,  10'd200, 10'd150};
    localparam t_beep BEEP_LOW      = '{1'b1, 4'd1,  10'd200, 10'd100};
    localparam t_beep BEEP_IDLE     = '{1'b1, 4'd2,  10'd800, 10'd600};
    localparam t_beep BEEP_LATCH    = '{1'b1, 4'd2,  10'd500, 10'd100};
    localparam t_beep BEEP_NAG      = '{1'b1, 4'd2,  10'd100, 10'd80};

endpackage

>>> hw/rtl/vlc_cfg_regs.sv
// ----------------------------------------------------------------------------
// vlc_cfg_regs
// Configuration register file, written through an index/data request.
// ----------------------------------------------------------------------------
module vlc_cfg_regs
    import vlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VOLTAGE_INTERVAL:    n_cfg.voltage_interval_ms    = i_cfg_data;
                CFG_INACTIVITY_LIMIT:    n_cfg.inactivity_limit_ms    = i_cfg_data;
                CFG_INACTIVITY_INTERVAL: n_cfg.inactivity_interval_ms = i_cfg_data;
                CFG_BLINK_NAG:           n_cfg.blink_nag_ms  = i_cfg_data[15:0];
                CFG_LONG_PRESS:          n_cfg.long_press_ms = i_cfg_data[15:0];
                CFG_ADC_CRITICAL:        n_cfg.adc_critical  = i_cfg_data[9:0];
                CFG_ADC_EMPTY:           n_cfg.adc_empty     = i_cfg_data[9:0];
                CFG_ADC_LOW:             n_cfg.adc_low       = i_cfg_data[9:0];
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.voltage_interval_ms    <= 32'd15000;
            r_cfg.inactivity_limit_ms    <= 32'd36000000;
            r_cfg.inactivity_interval_ms <= 32'd20000;
            r_cfg.blink_nag_ms           <= 16'd5000;
            r_cfg.long_press_ms          <= 16'd600;
            r_cfg.adc_critical           <= 10'd656;
            r_cfg.adc_empty              <= 10'd681;
            r_cfg.adc_low                <= 10'd730;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/vlc_pass.sv
// ----------------------------------------------------------------------------
// vlc_pass
// One control pass: checks, high-beam FSM, lamp logic and the pass state.
// ----------------------------------------------------------------------------
module vlc_pass
    import vlc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_beam_mode  r_mode, n_mode;
    logic        r_high_on, n_high_on;
    logic        r_first_done, n_first_done;
    logic [31:0] r_last_volt, n_last_volt;
    logic [31:0] r_last_idle, n_last_idle;
    logic [31:0] r_last_act, n_last_act;
    logic [31:0] r_blink_start, n_blink_start;

    logic [7:0]  lv;
    logic [7:0]  rs;
    logic [31:0] now;
    logic [31:0] volt_due;
    logic [31:0] volt_age;
    logic [31:0] idle_age;
    logic [31:0] act_age;
    logic [31:0] blink_age;
    logic        volt_check;
    logic        idle_check;
    logic        latch_beep;
    logic        nag;
    logic        restart;
    logic        blink;
    logic        left_on;
    logic        right_on;
    t_beep       beep;
    logic [7:0]  lamps;

    assign lv  = i_item.switch_levels;
    assign rs  = i_item.switch_rises;
    assign now = i_item.now_ms;

    always_comb begin
        volt_due   = r_first_done ? i_cfg.voltage_interval_ms : INITIAL_CHECK_MS;
        volt_age   = now - r_last_volt;
        idle_age   = now - r_last_idle;
        act_age    = now - r_last_act;
        volt_check = volt_age > volt_due;
        idle_check = idle_age > i_cfg.inactivity_interval_ms;

        n_first_done = r_first_done | volt_check;
        n_last_volt  = volt_check ? now : r_last_volt;
        n_last_idle  = idle_check ? now : r_last_idle;
        n_last_act   = ((rs & ~(8'd1 << SW_LOW)) != 8'd0) ? now : r_last_act;

        // high-beam FSM
        n_mode     = r_mode;
        n_high_on  = r_high_on;
        latch_beep = 1'b0;
        unique case (r_mode)
            BEAM_HELD: begin
                if (lv[SW_HIGH]) begin
                    if ((i_item.high_beam_press_ms > i_cfg.long_press_ms) && lv[SW_LOW]) begin
                        n_mode     = BEAM_LATCHED;
                        latch_beep = 1'b1;
                    end
                end else begin
                    n_mode    = BEAM_OFF;
                    n_high_on = 1'b0;
                end
            end
            BEAM_LATCHED: begin
                if (rs[SW_HIGH] || !lv[SW_LOW]) begin
                    n_mode    = BEAM_OFF;
                    n_high_on = 1'b0;
                end
            end
            default: begin
                if (rs[SW_HIGH]) begin
                    n_mode    = BEAM_HELD;
                    n_high_on = 1'b1;
                end
            end
        endcase

        restart       = rs[SW_LEFT] | rs[SW_RIGHT] | rs[SW_WARN];
        blink         = i_item.blink_level | restart;
        n_blink_start = (rs[SW_LEFT] | rs[SW_RIGHT]) ? now : r_blink_start;
        blink_age     = now - n_blink_start;
        nag = (lv[SW_LEFT] | lv[SW_RIGHT]) && !lv[SW_WARN] &&
              (blink_age > {16'd0, i_cfg.blink_nag_ms}) && i_item.blink_rise;

        // later triggers override earlier ones
        beep = BEEP_NONE;
        if (volt_check) begin
            if (i_item.battery_adc < i_cfg.adc_critical) beep = BEEP_CRITICAL;
            else if (i_item.battery_adc < i_cfg.adc_empty) beep = BEEP_EMPTY;
            else if (i_item.battery_adc < i_cfg.adc_low) beep = BEEP_LOW;
        end
        if (idle_check && (act_age > i_cfg.inactivity_limit_ms)) beep = BEEP_IDLE;
        if (latch_beep) beep = BEEP_LATCH;
        if (nag) beep = BEEP_NAG;

        lamps            = 8'd0;
        lamps[LAMP_WORK] = lv[SW_WORK];
        lamps[LAMP_LOW]  = lv[SW_LOW] & ~r_high_on;
        lamps[LAMP_HIGH] = n_high_on;
        lamps[LAMP_HORN] = lv[SW_HORN];

        left_on  = lv[SW_LEFT] | lv[SW_WARN];
        right_on = lv[SW_RIGHT] | lv[SW_WARN];
        // brake holds the rear lamp on a side with no turn or warning switch on
        if (lv[SW_BRAKE] && !left_on) begin
            lamps[LAMP_REAR_LEFT] = 1'b1;
        end else if (left_on && blink) begin
            lamps[LAMP_REAR_LEFT]  = 1'b1;
            lamps[LAMP_FRONT_LEFT] = 1'b1;
        end
        if (lv[SW_BRAKE] && !right_on) begin
            lamps[LAMP_REAR_RIGHT] = 1'b1;
        end else if (right_on && blink) begin
            lamps[LAMP_REAR_RIGHT]  = 1'b1;
            lamps[LAMP_FRONT_RIGHT] = 1'b1;
        end

        o_result.lamp_outputs  = lamps;
        o_result.blink_restart = restart;
        o_result.beep_request  = beep.request;
        o_result.beep_count    = beep.count;
        o_result.beep_on_ms    = beep.on_ms;
        o_result.beep_off_ms   = beep.off_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= BEAM_OFF;
            r_high_on     <= 1'b0;
            r_first_done  <= 1'b0;
            r_last_volt   <= 32'd0;
            r_last_idle   <= 32'd0;
            r_last_act    <= 32'd0;
            r_blink_start <= 32'd0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_high_on     <= n_high_on;
            r_first_done  <= n_first_done;
            r_last_volt   <= n_last_volt;
            r_last_idle   <= n_last_idle;
            r_last_act    <= n_last_act;
            r_blink_start <= n_blink_start;
        end
    end

endmodule

>>> hw/rtl/vehicle_lighting_controller_unit.sv
// ----------------------------------------------------------------------------
// vehicle_lighting_controller_unit
// Lighting control pass with battery, inactivity and blink-nag beep requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one control
//   pass request; output channel (o_out_valid / i_out_ready / o_out_item)
//   returns exactly one result per request. The config channel
//   (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is always ready;
//   write it only while no request is in flight. Unknown indexes are dropped.
//   The accepting edge loads the input register; the pass result is loaded
//   into the output register when the request is processed, which waits while
//   a stalled result occupies it. Throughput: one request per cycle while results
//   are taken, set by the combinational pass between the two registers; the pass
//   state updates on the edge that loads the result.
//   Reset (synchronous, active low) empties both registers, puts the high
//   beam FSM to off, clears all timestamps and loads register defaults.
//   When the receiver stalls the result holds; one more request is taken
//   into the input register, then o_in_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module vehicle_lighting_controller_unit
    import vlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      fire;
    t_cfg      cfg;
    t_out_item result;

    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    vlc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vlc_pass u_pass (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && r_in_valid))
        else $error("input held off without an output stall");

    a_fire_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("processed request produced no result");

    a_no_beep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.beep_request) |->
            (o_out_item.beep_count == 4'd0 && o_out_item.beep_on_ms == 10'd0 &&
             o_out_item.beep_off_ms == 10'd0))
        else $error("beep fields set without a beep request");

    a_request_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid)
        else $error("buffered request lost");

endmodule

>>> sim/vehicle_lighting_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// vehicle_lighting_controller_unit_tb
// Self-checking bench for the lighting control pass. A short table of
// directed passes is run first, followed by randomized switch, blink and
// time sequences under several register settings. Every accepted pass is
// predicted in the bench and compared field by field with the returned
// result, with random stalls on both channels except in the last setting.
// ----------------------------------------------------------------------------
module vehicle_lighting_controller_unit_tb;
    import vlc_pkg::*;

    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES     = 8;

    // Beep patterns of each trigger
    localparam t_beep PAT_NONE  = '{1'b0, 4'd0,  10'd0,   10'd0};
    localparam t_beep PAT_CRIT  = '{1'b1, 4'd10, 10'd300, 10'd150};
    localparam t_beep PAT_EMPTY = '{1'b1, 4'd4,  10'd200, 10'd150};
    localparam t_beep PAT_LOW   = '{1'b1, 4'd1,  10'd200, 10'd100};
    localparam t_beep PAT_IDLE  = '{1'b1, 4'd2,  10'd800, 10'd600};
    localparam t_beep PAT_LATCH = '{1'b1, 4'd2,  10'd500, 10'd100};
    localparam t_beep PAT_NAG   = '{1'b1, 4'd2,  10'd100, 10'd80};

    typedef struct {
        t_in_item  item;
        logic      typed;
        t_out_item result;
    } t_pass_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // Lighting state mirror
    t_cfg        cfg_model = '{32'd15000, 32'd36000000, 32'd20000, 16'd5000,
                               16'd600, 10'd656, 10'd681, 10'd730};
    t_beam_mode  beam_state       = BEAM_OFF;
    logic        high_lit         = 1'b0;
    logic        first_check_seen = 1'b0;
    logic [31:0] volt_checked_at  = '0;
    logic [31:0] idle_checked_at  = '0;
    logic [31:0] active_at        = '0;
    logic [31:0] blink_began_at   = '0;

    t_out_item   expected_results[$];
    t_pass_row   pass_table[$];
    t_out_item   want;
    int          mismatches    = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    logic        idle_on       = 1'b1;

    vehicle_lighting_controller_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    initial begin
        #2_000_000;
        $display("vehicle_lighting_controller_unit_tb: FAIL");
        $finish;
    end

    function automatic t_out_item predict_pass(input t_in_item it);
        t_out_item   res;
        t_beep       bp;
        logic [7:0]  lv;
        logic [7:0]  rs;
        logic [7:0]  lamps;
        logic        blink;
        logic        restart;
        logic        prev_high;
        logic [31:0] due;
        logic [31:0] elapsed;
        lv        = it.switch_levels;
        rs        = it.switch_rises;
        lamps     = '0;
        bp        = PAT_NONE;
        blink     = it.blink_level;
        prev_high = high_lit;

        due     = first_check_seen ? cfg_model.voltage_interval_ms : INITIAL_CHECK_MS;
        elapsed = it.now_ms - volt_checked_at;
        if (elapsed > due) begin
            volt_checked_at  = it.now_ms;
            first_check_seen = 1'b1;
            if (it.battery_adc < cfg_model.adc_critical)
                bp = PAT_CRIT;
            else if (it.battery_adc < cfg_model.adc_empty)
                bp = PAT_EMPTY;
            else if (it.battery_adc < cfg_model.adc_low)
                bp = PAT_LOW;
        end

        elapsed = it.now_ms - idle_checked_at;
        if (elapsed > cfg_model.inactivity_interval_ms) begin
            idle_checked_at = it.now_ms;
            elapsed = it.now_ms - active_at;
            if (elapsed > cfg_model.inactivity_limit_ms)
                bp = PAT_IDLE;
        end

        // Any rise except low beam counts as activity
        if (rs[7:1] != '0)
            active_at = it.now_ms;

        lamps[LAMP_WORK] = lv[SW_WORK];
        lamps[LAMP_LOW]  = lv[SW_LOW] && !prev_high;

        case (beam_state)
            BEAM_HELD: begin
                if (lv[SW_HIGH]) begin
                    if (it.high_beam_press_ms > cfg_model.long_press_ms && lv[SW_LOW]) begin
                        beam_state = BEAM_LATCHED;
                        bp = PAT_LATCH;
                    end
                end else begin
                    beam_state = BEAM_OFF;
                    high_lit   = 1'b0;
                end
            end
            BEAM_LATCHED: begin
                if (rs[SW_HIGH] || !lv[SW_LOW]) begin
                    beam_state = BEAM_OFF;
                    high_lit   = 1'b0;
                end
            end
            default: begin
                if (rs[SW_HIGH]) begin
                    high_lit   = 1'b1;
                    beam_state = BEAM_HELD;
                end
            end
        endcase
        lamps[LAMP_HIGH] = high_lit;
        lamps[LAMP_HORN] = lv[SW_HORN];

        restart = rs[SW_LEFT] || rs[SW_RIGHT] || rs[SW_WARN];
        if (restart)
            blink = 1'b1;
        if (rs[SW_LEFT] || rs[SW_RIGHT])
            blink_began_at = it.now_ms;

        elapsed = it.now_ms - blink_began_at;
        if ((lv[SW_LEFT] || lv[SW_RIGHT]) && !lv[SW_WARN] &&
            elapsed > {16'd0, cfg_model.blink_nag_ms} && it.blink_rise)
            bp = PAT_NAG;

        if (lv[SW_BRAKE] && !lv[SW_LEFT] && !lv[SW_WARN]) begin
            lamps[LAMP_REAR_LEFT] = 1'b1;
        end else if ((lv[SW_LEFT] || lv[SW_WARN]) && blink) begin
            lamps[LAMP_REAR_LEFT]  = 1'b1;
            lamps[LAMP_FRONT_LEFT] = 1'b1;
        end

        if (lv[SW_BRAKE] && !lv[SW_RIGHT] && !lv[SW_WARN]) begin
            lamps[LAMP_REAR_RIGHT] = 1'b1;
        end else if ((lv[SW_RIGHT] || lv[SW_WARN]) && blink) begin
            lamps[LAMP_REAR_RIGHT]  = 1'b1;
            lamps[LAMP_FRONT_RIGHT] = 1'b1;
        end

        res.lamp_outputs  = lamps;
        res.blink_restart = restart;
        res.beep_request  = bp.request;
        res.beep_count    = bp.count;
        res.beep_on_ms    = bp.on_ms;
        res.beep_off_ms   = bp.off_ms;
        return res;
    endfunction

    function automatic void add_row(input logic [7:0] lv, input logic [7:0] rs,
                                    input logic [15:0] press, input logic bl,
                                    input logic br, input logic [31:0] now,
                                    input logic [9:0] adc, input logic typed,
                                    input t_out_item res);
        t_pass_row row;
        row.item   = '{lv, rs, press, bl, br, now, adc};
        row.typed  = typed;
        row.result = res;
        pass_table.push_back(row);
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic send_pass(input t_in_item it, input logic typed, input t_out_item fixed);
        int        gap;
        t_out_item pred;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pred = predict_pass(it);
        expected_results.push_back(typed ? fixed : pred);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_VOLTAGE_INTERVAL:    cfg_model.voltage_interval_ms    = data;
            CFG_INACTIVITY_LIMIT:    cfg_model.inactivity_limit_ms    = data;
            CFG_INACTIVITY_INTERVAL: cfg_model.inactivity_interval_ms = data;
            CFG_BLINK_NAG:           cfg_model.blink_nag_ms           = data[15:0];
            CFG_LONG_PRESS:          cfg_model.long_press_ms          = data[15:0];
            CFG_ADC_CRITICAL:        cfg_model.adc_critical           = data[9:0];
            CFG_ADC_EMPTY:           cfg_model.adc_empty              = data[9:0];
            CFG_ADC_LOW:             cfg_model.adc_low                = data[9:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input t_cfg c);
        logic [31:0] d;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(CFG_VOLTAGE_INTERVAL, c.voltage_interval_ms);
        write_reg(CFG_INACTIVITY_LIMIT, c.inactivity_limit_ms);
        write_reg(CFG_INACTIVITY_INTERVAL, c.inactivity_interval_ms);
        // Upper bits of narrow registers carry junk that must be dropped
        d = $urandom;
        d[15:0] = c.blink_nag_ms;
        write_reg(CFG_BLINK_NAG, d);
        d = $urandom;
        d[15:0] = c.long_press_ms;
        write_reg(CFG_LONG_PRESS, d);
        d = $urandom;
        d[9:0] = c.adc_critical;
        write_reg(CFG_ADC_CRITICAL, d);
        d = $urandom;
        d[9:0] = c.adc_empty;
        write_reg(CFG_ADC_EMPTY, d);
        d = $urandom;
        d[9:0] = c.adc_low;
        write_reg(CFG_ADC_LOW, d);
        write_reg(8'($urandom_range(8, 255)), $urandom);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Switch, blink and time sequences: mostly well-formed, some noise
    logic [7:0]  gen_levels = '0;
    logic [15:0] gen_press  = '0;
    logic        gen_blink  = 1'b0;
    logic [31:0] gen_now    = '0;

    task automatic run_random(input int count, input int step_max, input logic pressure);
        logic [7:0]  prev_lv;
        logic        prev_bl;
        logic [16:0] sum;
        logic [9:0]  thr;
        t_in_item    it;
        for (int k = 0; k < count; k++) begin
            if (pressure && k == 30)
                hold_requests++;
            if (pressure && k == 60)
                wait_drained();
            prev_lv = gen_levels;
            prev_bl = gen_blink;
            for (int b = 0; b < 8; b++) begin
                if ($urandom_range(0, (b == SW_LOW) ? 23 : 7) == 0)
                    gen_levels[b] = ~gen_levels[b];
            end
            it.switch_levels = gen_levels;
            it.switch_rises  = gen_levels & ~prev_lv;
            if ($urandom_range(0, 15) == 0)
                it.switch_rises = 8'($urandom);

            if (!gen_levels[SW_HIGH] || it.switch_rises[SW_HIGH]) begin
                gen_press = '0;
            end else begin
                sum = {1'b0, gen_press} + 17'($urandom_range(0, 300));
                gen_press = sum[16] ? 16'hFFFF : sum[15:0];
            end
            it.high_beam_press_ms = gen_press;
            if ($urandom_range(0, 15) == 0)
                it.high_beam_press_ms = 16'($urandom);

            if ($urandom_range(0, 1) == 0)
                gen_blink = ~gen_blink;
            it.blink_level = gen_blink;
            it.blink_rise  = gen_blink && !prev_bl;
            if ($urandom_range(0, 15) == 0)
                it.blink_rise = 1'($urandom);

            if ($urandom_range(0, 39) == 0)
                gen_now = $urandom;
            else
                gen_now = gen_now + 32'($urandom_range(0, step_max));
            it.now_ms = gen_now;

            if ($urandom_range(0, 1) == 0) begin
                it.battery_adc = 10'($urandom_range(0, 1023));
            end else begin
                case ($urandom_range(0, 2))
                    0:       thr = cfg_model.adc_critical;
                    1:       thr = cfg_model.adc_empty;
                    default: thr = cfg_model.adc_low;
                endcase
                it.battery_adc = thr + 10'($urandom_range(0, 4)) - 10'd2;
            end
            send_pass(it, 1'b0, '0);
        end
    endtask

    // Result receiver ready generation
    initial begin : sink_ready
        int n;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_served < hold_requests) begin
                hold_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: lamps=%0h beep=%0b/%0d/%0d/%0d",
                             out_item.lamp_outputs, out_item.beep_request,
                             out_item.beep_count, out_item.beep_on_ms,
                             out_item.beep_off_ms);
            end else begin
                want = expected_results.pop_front();
                if (out_item.lamp_outputs  !== want.lamp_outputs  ||
                    out_item.blink_restart !== want.blink_restart ||
                    out_item.beep_request  !== want.beep_request  ||
                    out_item.beep_count    !== want.beep_count    ||
                    out_item.beep_on_ms    !== want.beep_on_ms    ||
                    out_item.beep_off_ms   !== want.beep_off_ms) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: lamps %0h/%0h restart %0b/%0b beep %0b/%0b cnt %0d/%0d on %0d/%0d off %0d/%0d",
                                 want.lamp_outputs, out_item.lamp_outputs,
                                 want.blink_restart, out_item.blink_restart,
                                 want.beep_request, out_item.beep_request,
                                 want.beep_count, out_item.beep_count,
                                 want.beep_on_ms, out_item.beep_on_ms,
                                 want.beep_off_ms, out_item.beep_off_ms);
                end
            end
        end
    end

    initial begin : stimulus
        logic [31:0] t;
        logic [31:0] tb;
        t_cfg        c;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed passes, default registers
        add_row(8'h00, 8'h00, 16'd0, 1'b0, 1'b0, 32'd0, 10'd0, 1'b1, '0);
        add_row(8'hFF, 8'h00, 16'd0, 1'b0, 1'b0, 32'd1, 10'd0, 1'b1,
                '{8'hD0, 1'b0, 1'b0, 4'd0, 10'd0, 10'd0});
        add_row(8'h00, 8'h00, 16'd0, 1'b0, 1'b0, 32'd1201, 10'd0, 1'b1,
                '{8'h00, 1'b0, 1'b1, 4'd10, 10'd300, 10'd150});
        t = 32'hF000_0000;
        add_row(8'h00, 8'h00, 16'd0, 1'b0, 1'b0, t, 10'd1023, 1'b1,
                '{8'h00, 1'b0, 1'b1, 4'd2, 10'd800, 10'd600});
        t = t + 32'd15001;
        add_row(8'h02, 8'h02, 16'd0, 1'b0, 1'b0, t, 10'd660, 1'b0, '0);
        t = t + 32'd15001;
        add_row(8'h02, 8'h00, 16'd0, 1'b0, 1'b0, t, 10'd700, 1'b0, '0);
        t = t + 32'd15001;
        add_row(8'h01, 8'h00, 16'd0, 1'b0, 1'b0, t, 10'd730, 1'b0, '0);
        // High beam: hold, press at and past the limit, latch, release
        add_row(8'h09, 8'h08, 16'd0,   1'b0, 1'b0, t + 32'd1, 10'd800, 1'b0, '0);
        add_row(8'h09, 8'h00, 16'd600, 1'b0, 1'b0, t + 32'd2, 10'd800, 1'b0, '0);
        add_row(8'h09, 8'h00, 16'd601, 1'b0, 1'b0, t + 32'd3, 10'd800, 1'b0, '0);
        add_row(8'h01, 8'h00, 16'd0,   1'b0, 1'b0, t + 32'd4, 10'd800, 1'b0, '0);
        add_row(8'h09, 8'h08, 16'd0,   1'b0, 1'b0, t + 32'd5, 10'd800, 1'b0, '0);
        add_row(8'h08, 8'h08, 16'd0,   1'b0, 1'b0, t + 32'd6, 10'd800, 1'b0, '0);
        add_row(8'h08, 8'h00, 16'hFFFF, 1'b0, 1'b0, t + 32'd7, 10'd800, 1'b0, '0);
        add_row(8'h00, 8'h00, 16'd0,   1'b0, 1'b0, t + 32'd8, 10'd800, 1'b0, '0);
        // Blinker restart with clock low, nag at and past the limit
        tb = t + 32'd9;
        add_row(8'h20, 8'h20, 16'd0, 1'b0, 1'b0, tb, 10'd800, 1'b0, '0);
        add_row(8'h20, 8'h00, 16'd0, 1'b1, 1'b1, tb + 32'd5000, 10'd800, 1'b0, '0);
        add_row(8'h20, 8'h00, 16'd0, 1'b1, 1'b1, tb + 32'd5001, 10'd800, 1'b0, '0);
        // Warning suppresses the nag, brake against blinkers, horn and work
        add_row(8'hA0, 8'h80, 16'd0, 1'b0, 1'b1, tb + 32'd5002, 10'd800, 1'b0, '0);
        add_row(8'h42, 8'h00, 16'd0, 1'b0, 1'b0, tb + 32'd5003, 10'd800, 1'b0, '0);
        add_row(8'h42, 8'h00, 16'd0, 1'b1, 1'b0, tb + 32'd5004, 10'd800, 1'b0, '0);
        add_row(8'h14, 8'h00, 16'd0, 1'b1, 1'b0, tb + 32'd5005, 10'd800, 1'b0, '0);
        // Field extremes and time wrap
        add_row(8'hFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 10'h3FF, 1'b0, '0);
        add_row(8'h00, 8'h00, 16'd0, 1'b0, 1'b0, 32'h0000_0010, 10'd0, 1'b0, '0);
        add_row(8'h01, 8'h00, 16'd0, 1'b0, 1'b0, 32'h0000_5000, 10'd0, 1'b0, '0);

        foreach (pass_table[i])
            send_pass(pass_table[i].item, pass_table[i].typed, pass_table[i].result);
        gen_now = 32'h0000_6000;

        // Short intervals, ordered thresholds; long hold and a full drain here
        c = '{32'd500, 32'd3000, 32'd400, 16'd800, 16'd700, 10'd600, 10'd700, 10'd800};
        load_config(c);
        run_random(100, 150, 1'b1);

        // Minimum values, low threshold at its maximum
        c = '{32'd1, 32'd1, 32'd1, 16'd0, 16'd0, 10'd0, 10'd0, 10'd1023};
        load_config(c);
        run_random(100, 5, 1'b0);

        // Maximum values
        c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
              10'd1023, 10'd1023, 10'd1023};
        load_config(c);
        run_random(100, 20000, 1'b0);

        // Random settings, no idling
        c.voltage_interval_ms    = $urandom_range(1, 2000);
        c.inactivity_limit_ms    = $urandom_range(1, 5000);
        c.inactivity_interval_ms = $urandom_range(1, 2000);
        c.blink_nag_ms           = 16'($urandom_range(0, 3000));
        c.long_press_ms          = 16'($urandom_range(0, 1500));
        c.adc_critical           = 10'($urandom);
        c.adc_empty              = 10'($urandom);
        c.adc_low                = 10'($urandom);
        load_config(c);
        idle_on = 1'b0;
        run_random(100, 200, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("vehicle_lighting_controller_unit_tb: PASS");
        else
            $display("vehicle_lighting_controller_unit_tb: FAIL");
        $finish;
    end

endmodule
